// ----- sv/bounded_double_ended_queue_unit_assert.svh -----
// Assertion macros for the bounded deque unit.
// Used by the port-level checker; no other dependencies.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Implication checked on every rising edge, masked while in reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with a plain boolean condition.
`define BDQ_ASSERT_COND(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- sv/bdq_pkg.sv -----
// Shared types and constants for the bounded deque unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 9;
  localparam int FUNC_W = 3;
  localparam int WORD_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [CAP_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- sv/bounded_double_ended_queue_unit.sv -----
// Bounded deque unit, top level: controller plus datapath (bdq_pkg).
// A request is taken only while idle; it then runs through capture, execute,
// read and deliver around the single-write, dual-read ring store, and a new
// request is taken only after the result is loaded into the output register.
// Reset: synchronous active-low; pointers and count clear, capacity to 256,
// store contents are left as they are.
`timescale 1ns / 1ps

module bounded_double_ended_queue_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bdq_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bdq_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data
);
  import bdq_pkg::*;

  cmd_t    cmd;
  status_t status;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bdq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- sv/bdq_ctrl.sv -----
// Sequencer for the bounded deque unit: capture, execute, read, deliver.
// Depends on bdq_pkg for the state and command types.
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bdq_pkg::status_t status,
  output bdq_pkg::cmd_t    cmd
);
  import bdq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/bdq_datapath.sv -----
// Datapath of the bounded deque unit: ring store, pointers, count,
// capacity register and output register. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bdq_pkg::in_t            in_data,
  input  logic                    cfg_wr_en,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data,
  input  bdq_pkg::cmd_t           cmd,
  output bdq_pkg::status_t        status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bdq_pkg::out_t           out_data
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] word_r;
  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [PTR_W-1:0]  back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] rd_front_r, rd_back_r;
  logic              out_valid_r;
  out_t              out_r, out_nxt;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  lim;
  logic              has_room;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    ring_prev = (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // capacity above the store depth is clamped to the depth
  always_comb begin
    if (32'(cap_r) > DEPTH) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(cap_r);
    end
  end

  assign has_room = (count_r < lim);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    case (func_r)
      FN_INS_FRONT: begin
        if (has_room) begin
          if (count_r == '0) begin
            back_nxt = front_r;
          end else begin
            front_nxt = ring_prev(front_r);
          end
          wr_en     = 1'b1;
          wr_addr   = front_nxt;
          count_nxt = count_r + CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      FN_INS_BACK: begin
        if (has_room) begin
          if (count_r == '0) begin
            front_nxt = back_r;
          end else begin
            back_nxt = ring_next(back_r);
          end
          wr_en     = 1'b1;
          wr_addr   = back_nxt;
          count_nxt = count_r + CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      FN_REM_FRONT: begin
        if (count_r != '0) begin
          if (count_r > CNT_W'(1)) begin
            front_nxt = ring_next(front_r);
          end
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      FN_REM_BACK: begin
        if (count_r != '0) begin
          if (count_r > CNT_W'(1)) begin
            back_nxt = ring_prev(back_r);
          end
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      FN_QUERY: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= word_r;
    end
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_data.func;
      word_r <= DATA_W'(in_data.data_value);
    end
    if (cmd.exec) begin
      ok_r <= ok_nxt;
    end
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        count_r <= count_nxt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt.accepted    = ok_r;
    out_nxt.front_value = (count_r == '0) ? '0 : WORD_W'(rd_front_r);
    out_nxt.back_value  = (count_r == '0) ? '0 : WORD_W'(rd_back_r);
    out_nxt.entry_count = CAP_W'(count_r);
    out_nxt.is_empty    = (count_r == '0);
    out_nxt.is_full     = (count_r >= lim);
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

// ----- sv/bdq_checker.sv -----
// Port-level checker for the bounded deque unit, bound to the top level.
// Depends on bdq_pkg and bounded_double_ended_queue_unit_assert.svh.
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_assert.svh"

module bdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  `BDQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")
  `BDQ_ASSERT(a_busy_after_req, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "request taken while busy")
  `BDQ_ASSERT(a_empty_flag, clk, rst_n, out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)), "empty flag disagrees with count")
  `BDQ_ASSERT(a_empty_zero, clk, rst_n, (out_valid && out_data.is_empty) |-> (out_data.front_value == '0 && out_data.back_value == '0), "empty queue shows data")
  `BDQ_ASSERT_COND(a_count_max, clk, rst_n, !out_valid || (32'(out_data.entry_count) <= DEPTH), "count above depth")

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
